FILE: hw/rtl/hns_pkg.sv
// ----------------------------------------------------------------------------
// hns_pkg
// Shared constants and controller/datapath interface types of the height map
// normal stream.
// ----------------------------------------------------------------------------
package hns_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = COL_W + 1;
  localparam int ROW_W     = 16;
  localparam int HEIGHT_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int Q14_W     = 15;
  localparam int NRM_W     = 16;

  localparam logic [Q14_W-1:0] Q14_ONE = 15'd16384;

  localparam int OUT_FIELDS_W = 2 * NRM_W + Q14_W + COL_W + ROW_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SPACING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GAIN  = 2'd3;

  // Input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic capture;
    logic rd0;
    logic rd1;
    logic rd2;
    logic commit;
    logic diff;
    logic mulg;
    logic muls;
    logic norm;
    logic square;
    logic sum;
    logic sqrt_step;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic produce;
    logic norm_done;
    logic sqrt_last;
    logic div_last;
    logic comp_last;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/hns_ctrl.sv
// ----------------------------------------------------------------------------
// hns_ctrl
// Sequencer: steps one item through line store access, slope products,
// normalisation, square root and the three component divisions.
// ----------------------------------------------------------------------------
module hns_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hns_pkg::status_t st_i,
  output hns_pkg::cmd_t   cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CHECK  = 16'h0002,
    S_RD0    = 16'h0004,
    S_RD1    = 16'h0008,
    S_RD2    = 16'h0010,
    S_COMMIT = 16'h0020,
    S_DIFF   = 16'h0040,
    S_MULG   = 16'h0080,
    S_MULS   = 16'h0100,
    S_NORM   = 16'h0200,
    S_SQUARE = 16'h0400,
    S_SUM    = 16'h0800,
    S_SQRT   = 16'h1000,
    S_DLOAD  = 16'h2000,
    S_DIV    = 16'h4000,
    S_OUTPUT = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK:  state_d = st_i.active ? S_RD0 : S_IDLE;
      S_RD0: begin
        cmd_o.rd0 = 1'b1;
        state_d   = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd1 = 1'b1;
        state_d   = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd2 = 1'b1;
        state_d   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = st_i.produce ? S_DIFF : S_IDLE;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_MULG;
      end
      S_MULG: begin
        cmd_o.mulg = 1'b1;
        state_d    = S_MULS;
      end
      S_MULS: begin
        cmd_o.muls = 1'b1;
        state_d    = S_NORM;
      end
      S_NORM: begin
        if (st_i.norm_done) begin
          state_d = S_SQUARE;
        end else begin
          cmd_o.norm = 1'b1;
        end
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (st_i.sqrt_last) begin
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = st_i.comp_last ? S_OUTPUT : S_DLOAD;
        end
      end
      S_OUTPUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/hns_dp.sv
// ----------------------------------------------------------------------------
// hns_dp
// Datapath: configuration, grid position counters, two line stores, slope
// products, bit-serial square root and divider, and the output register.
// ----------------------------------------------------------------------------
module hns_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hns_pkg::cmd_t                    cmd_i,
  output hns_pkg::status_t                 st_o,
  input  logic                             in_cmd_i,
  input  logic [hns_pkg::HEIGHT_W-1:0]     in_height_i,
  input  logic                             cfg_we_i,
  input  logic [hns_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hns_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hns_pkg::OUT_TDATA_W-1:0]  out_data_o,
  output logic                             out_last_o
);

  localparam int COL_W = hns_pkg::COL_W;
  localparam int WW    = hns_pkg::WIDTH_W;
  localparam int RW    = hns_pkg::ROW_W;
  localparam int HW    = hns_pkg::HEIGHT_W;

  // Configuration
  logic [WW-1:0] grid_width_q;
  logic [RW-1:0] grid_rows_q;
  logic [15:0]   cell_spacing_q, height_gain_q;
  logic [WW-1:0] wd;
  logic [RW-1:0] rows;
  logic          restart;

  assign wd = (grid_width_q == '0) ? WW'(1) :
              (grid_width_q > WW'(hns_pkg::MAX_WIDTH)) ? WW'(hns_pkg::MAX_WIDTH) : grid_width_q;
  assign rows = (grid_rows_q == '0) ? RW'(1) : grid_rows_q;
  assign restart = cfg_we_i && (cfg_index_i == hns_pkg::CFG_GRID_WIDTH ||
                                cfg_index_i == hns_pkg::CFG_GRID_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= WW'(1024);
      grid_rows_q    <= RW'(1024);
      cell_spacing_q <= 16'd256;
      height_gain_q  <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hns_pkg::CFG_GRID_WIDTH:   grid_width_q   <= cfg_wdata_i[WW-1:0];
        hns_pkg::CFG_GRID_ROWS:    grid_rows_q    <= cfg_wdata_i[RW-1:0];
        hns_pkg::CFG_CELL_SPACING: cell_spacing_q <= cfg_wdata_i;
        hns_pkg::CFG_HEIGHT_GAIN:  height_gain_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Item capture and grid position
  logic [COL_W-1:0] in_col_q, flush_col_q, c_q, c_cap;
  logic [RW-1:0]    in_row_q, tr_q;
  logic             is_flush_q, active_q, produce_q, end_q;
  logic [HW-1:0]    h_q;
  logic [WW-1:0]    c_cap_inc, c_inc;
  logic [COL_W-1:0] x0, x1;
  logic             tr_zero;

  assign c_cap     = (in_cmd_i == hns_pkg::CMD_FLUSH) ? flush_col_q : in_col_q;
  assign c_cap_inc = {1'b0, c_cap} + WW'(1);
  assign c_inc     = {1'b0, c_q} + WW'(1);
  assign x0        = (c_q == '0) ? c_q : c_q - COL_W'(1);
  assign x1        = (c_inc < wd) ? c_inc[COL_W-1:0] : c_q;
  assign tr_zero   = (tr_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_flush_q <= (in_cmd_i == hns_pkg::CMD_FLUSH);
      h_q        <= in_height_i;
      c_q        <= c_cap;
      tr_q       <= (in_cmd_i == hns_pkg::CMD_FLUSH) ? rows - RW'(1) : in_row_q - RW'(1);
      end_q      <= (in_cmd_i == hns_pkg::CMD_FLUSH) && (c_cap_inc >= wd);
      if (in_cmd_i == hns_pkg::CMD_FLUSH) begin
        active_q  <= (in_row_q >= rows);
        produce_q <= (in_row_q >= rows);
      end else begin
        active_q  <= (in_row_q < rows);
        produce_q <= (in_row_q < rows) && (in_row_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      flush_col_q <= '0;
    end else if (restart) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      flush_col_q <= '0;
    end else if (cmd_i.commit) begin
      if (!is_flush_q) begin
        if (c_inc >= wd) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RW'(1);
        end else begin
          in_col_q <= c_inc[COL_W-1:0];
        end
      end else if (end_q) begin
        in_col_q    <= '0;
        in_row_q    <= '0;
        flush_col_q <= '0;
      end else begin
        flush_col_q <= c_inc[COL_W-1:0];
      end
    end
  end

  // Line stores: three read phases, then the write of the current column.
  logic [HW-1:0]    older_mem [hns_pkg::MAX_WIDTH];
  logic [HW-1:0]    newer_mem [hns_pkg::MAX_WIDTH];
  logic [HW-1:0]    older_rd_q, newer_rd_q;
  logic [COL_W-1:0] older_addr, newer_addr;
  logic [HW-1:0]    older_c_q, newer_c_q, older_x0_q, newer_x1_q, newer_x0_q;

  assign older_addr = cmd_i.rd0 ? c_q : x0;
  assign newer_addr = cmd_i.rd0 ? c_q : (cmd_i.rd1 ? x1 : x0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd0 || cmd_i.rd1) begin
      older_rd_q <= older_mem[older_addr];
    end
    if (cmd_i.rd0 || cmd_i.rd1 || cmd_i.rd2) begin
      newer_rd_q <= newer_mem[newer_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !is_flush_q) begin
      older_mem[c_q] <= newer_c_q;
      newer_mem[c_q] <= h_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd1) begin
      older_c_q <= older_rd_q;
      newer_c_q <= newer_rd_q;
    end
    if (cmd_i.rd2) begin
      older_x0_q <= older_rd_q;
      newer_x1_q <= newer_rd_q;
    end
    if (cmd_i.commit) begin
      newer_x0_q <= newer_rd_q;
    end
  end

  // Height differences and steps
  function automatic logic [16:0] step_len(input logic [1:0] span, input logic [15:0] sp);
    logic [16:0] s;
    case (span)
      2'd1:    s = {1'b0, sp};
      2'd2:    s = {sp, 1'b0};
      default: s = '0;
    endcase
    return (s < 17'd256) ? 17'd256 : s;
  endfunction

  logic signed [HW-1:0] hx0, hx1, hz0, hz1;
  logic signed [HW:0]   dx, dz;
  logic [HW:0]          adx_full, adz_full;
  logic [1:0]           spx, spz;
  logic [HW-1:0]        adx_q, adz_q;
  logic                 dxpos_q, dzpos_q;
  logic [16:0]          q_q, s_q;

  always_comb begin
    if (is_flush_q) begin
      hx0 = newer_x0_q;
      hx1 = newer_x1_q;
      hz1 = newer_c_q;
      spz = tr_zero ? 2'd0 : 2'd1;
    end else begin
      hx0 = (x0 < c_q) ? older_x0_q : newer_c_q;
      hx1 = (x1 > c_q) ? newer_x1_q : newer_c_q;
      hz1 = h_q;
      spz = tr_zero ? 2'd1 : 2'd2;
    end
    hz0      = tr_zero ? newer_c_q : older_c_q;
    spx      = 2'(x1 - x0);
    dx       = (HW+1)'(hx1) - (HW+1)'(hx0);
    dz       = (HW+1)'(hz1) - (HW+1)'(hz0);
    adx_full = dx[HW] ? (HW+1)'(-dx) : dx;
    adz_full = dz[HW] ? (HW+1)'(-dz) : dz;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      adx_q   <= adx_full[HW-1:0];
      adz_q   <= adz_full[HW-1:0];
      dxpos_q <= !dx[HW] && (dx != '0);
      dzpos_q <= !dz[HW] && (dz != '0);
      q_q     <= step_len(spx, cell_spacing_q);
      s_q     <= step_len(spz, cell_spacing_q);
    end
  end

  // Products, normalisation and squares
  logic [31:0] p_q, r_q;
  logic [48:0] u_q, v_q, w_q;
  logic [59:0] su_q, sv_q, sw_q;

  assign st_o.norm_done = ~|{u_q[48:30], v_q[48:30], w_q[48:30]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mulg) begin
      p_q <= 32'(adx_q) * 32'(height_gain_q);
      r_q <= 32'(adz_q) * 32'(height_gain_q);
    end
    if (cmd_i.muls) begin
      u_q <= 49'(p_q) * 49'(s_q);
      v_q <= 49'(q_q) * 49'(s_q);
      w_q <= 49'(r_q) * 49'(q_q);
    end else if (cmd_i.norm) begin
      u_q <= u_q >> 1;
      v_q <= v_q >> 1;
      w_q <= w_q >> 1;
    end
    if (cmd_i.square) begin
      su_q <= 60'(u_q[29:0]) * 60'(u_q[29:0]);
      sv_q <= 60'(v_q[29:0]) * 60'(v_q[29:0]);
      sw_q <= 60'(w_q[29:0]) * 60'(w_q[29:0]);
    end
  end

  // Square root, two radicand bits per step
  logic [62:0] x_q, rt_q, b_q, trial;
  logic [30:0] len;

  assign trial          = rt_q + b_q;
  assign st_o.sqrt_last = b_q[0];
  assign len            = (rt_q[30:0] == '0) ? 31'd1 : rt_q[30:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      x_q  <= 63'(su_q) + 63'(sv_q) + 63'(sw_q);
      rt_q <= '0;
      b_q  <= 63'd1 << 62;
    end else if (cmd_i.sqrt_step) begin
      if (x_q >= trial) begin
        x_q  <= x_q - trial;
        rt_q <= (rt_q >> 1) + b_q;
      end else begin
        rt_q <= rt_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  // Restoring divider, one quotient bit per step, shared by the components
  logic [44:0]               num_q, ds_q;
  logic [hns_pkg::Q14_W-1:0] quo_q, quo_next, quo_sat;
  logic [3:0]                dcnt_q;
  logic [1:0]                comp_q;
  logic [29:0]               comp_val;
  logic [hns_pkg::Q14_W-1:0] res_q [3];
  logic                      ge;

  assign comp_val = (comp_q == 2'd0) ? u_q[29:0] : (comp_q == 2'd1) ? v_q[29:0] : w_q[29:0];
  assign ge       = (num_q >= ds_q);
  assign quo_next = {quo_q[hns_pkg::Q14_W-2:0], ge};
  assign quo_sat  = (quo_next > hns_pkg::Q14_ONE) ? hns_pkg::Q14_ONE : quo_next;
  assign st_o.div_last  = (dcnt_q == '0);
  assign st_o.comp_last = (comp_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      comp_q <= '0;
    end
    if (cmd_i.div_load) begin
      num_q  <= {1'b0, comp_val, 14'd0} + 45'(len >> 1);
      ds_q   <= {len, 14'd0};
      quo_q  <= '0;
      dcnt_q <= 4'd14;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        num_q <= num_q - ds_q;
      end
      ds_q   <= ds_q >> 1;
      quo_q  <= quo_next;
      dcnt_q <= dcnt_q - 4'd1;
      if (dcnt_q == '0) begin
        res_q[comp_q] <= quo_sat;
        comp_q        <= comp_q + 2'd1;
      end
    end
  end

  // Output register
  logic [hns_pkg::NRM_W-1:0] nx, nz;
  logic                      out_valid_q, out_last_q;
  logic [hns_pkg::OUT_TDATA_W-1:0] out_data_q;

  assign nx = dxpos_q ? hns_pkg::NRM_W'(-{1'b0, res_q[0]}) : {1'b0, res_q[0]};
  assign nz = dzpos_q ? hns_pkg::NRM_W'(-{1'b0, res_q[2]}) : {1'b0, res_q[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= hns_pkg::OUT_TDATA_W'({tr_q, c_q, nz, res_q[1], nx});
      out_last_q <= end_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;
  assign out_last_o    = out_last_q;
  assign st_o.out_free = !out_valid_q || out_ready_i;
  assign st_o.active   = active_q;
  assign st_o.produce  = produce_q;

endmodule

FILE: hw/rtl/heightmap_normal_stream.sv
// ----------------------------------------------------------------------------
// heightmap_normal_stream
// Unit surface normals of a streamed height grid, one row behind the input.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tdata: sample_height; tuser: command (1 = flush)
//  m_axis    out  tdata: normal_x, normal_y, normal_z, column, row; tlast: frame_end
//  cfg       in   cfg_we_i, cfg_index_i, cfg_wdata_i (write only)
//
// A dropped item and a first-row sample give no result; an item with a result
// runs the 32-step square root, three 15-step divisions and up to 19 normalising
// shifts. Reset clears the controller and counters and loads the default
// configuration; the line stores are not cleared. A waiting result stalls only
// the end of the next item.
// ----------------------------------------------------------------------------
module heightmap_normal_stream (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hns_pkg::HEIGHT_W-1:0]    s_axis_tdata,  // [15:0] sample_height
  input  logic                            s_axis_tuser,  // [0] command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] normal_x, [30:16] normal_y, [46:31] normal_z, [56:47] column, [72:57] row
  output logic [hns_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [hns_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hns_pkg::CFG_W-1:0]       cfg_wdata_i
);

  hns_pkg::cmd_t    cmd;
  hns_pkg::status_t st;

  hns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  hns_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_cmd_i    (s_axis_tuser),
    .in_height_i (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // One item at a time: no transfer directly after another.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input transfer in the cycle after another");

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a waiting one");

  // A new result only appears after the controller loaded one.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a load");

endmodule
